// ===== hdl/markf_pkg.sv =====
// Shared types and constants for the minimum-area free-cell rectangle search.
package markf_pkg;

	// Configuration port geometry
	localparam int CFG_DATA_W = 32;
	localparam int CFG_ADDR_W = 4;
	localparam int DIM_W      = 9;
	localparam int MIN_FREE_W = 17;
	localparam int AREA_OUT_W = 17;

	// Register indexes (byte address 4*index)
	localparam logic [1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [1:0] REG_COL_COUNT = 2'd1;
	localparam logic [1:0] REG_MIN_FREE  = 2'd2;

	// Corner reads of one rectangle count, in issue order
	localparam logic [1:0] CRN_LOW_RIGHT = 2'd0;
	localparam logic [1:0] CRN_LOW_LEFT  = 2'd1;
	localparam logic [1:0] CRN_TOP_RIGHT = 2'd2;
	localparam logic [1:0] CRN_TOP_LEFT  = 2'd3;

	// Control of the shared accumulate unit
	typedef struct packed {
		logic add;     // update the accumulator this cycle
		logic first;   // start from zero
		logic negate;  // subtract the term
		logic take;    // term is the table data, else zero
	} acc_ctl_t;

endpackage

// ===== hdl/markf_table_ram.sv =====
// Summed-area table memory: one write port, one registered read port.
module markf_table_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	// Write the new entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read every cycle, data in the next cycle
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/markf_acc_unit.sv =====
// Shared add/subtract accumulator that builds a rectangle count and checks it against the threshold.
module markf_acc_unit #(
	parameter int DW    = 17,
	parameter int ACC_W = 19
) (
	input  logic                                clk,
	input  markf_pkg::acc_ctl_t                 ctl,
	input  logic [DW-1:0]                       data,
	input  logic [markf_pkg::MIN_FREE_W-1:0]    need,
	output logic                                enough
);

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ACC_W-1:0] term;
	logic signed [ACC_W-1:0] base;
	logic signed [ACC_W-1:0] need_ext;

	// Select the term and the starting value
	assign term     = ctl.take ? $signed({{(ACC_W-DW){1'b0}}, data}) : '0;
	assign base     = ctl.first ? '0 : acc_q;
	assign need_ext = $signed({{(ACC_W-markf_pkg::MIN_FREE_W){1'b0}}, need});

	// Accumulate one corner per cycle while add is set
	always_ff @(posedge clk) begin
		if (ctl.add) begin
			acc_q <= ctl.negate ? (base - term) : (base + term);
		end
	end

	assign enough = (acc_q >= need_ext);

endmodule

// ===== hdl/min_area_rect_k_free_cells_top.sv =====
// Load: each cell first reads the table entry of the row above, then writes its own.
// After the last cell the search runs: a start step, then for every column pair a
// pair step plus, per row-pointer step, 4 table reads through one port into the
// shared accumulator and a decision step, and one more step when a rectangle
// qualifies; a final step registers the area, held while an earlier area is still
// stalled on the output. A new grid is taken only once that area is registered.
// Reset: control and pointers clear, row and column counts and threshold return to 1,
// table contents are undefined until written by a grid.
module min_area_rect_k_free_cells_top #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [markf_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [markf_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [markf_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                 pready,
	// cell channel
	input  logic                                 cell_valid,
	output logic                                 cell_stall,
	input  logic                                 cell_free,
	// result channel
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output logic [markf_pkg::AREA_OUT_W-1:0]     min_area
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int TW     = $clog2(DEPTH + 1);
	localparam int RCW    = $clog2(MAX_ROWS + 1);
	localparam int CCW    = $clog2(MAX_COLS + 1);
	localparam int AREA_W = RCW + CCW;
	localparam int ACC_W  = ((TW > markf_pkg::MIN_FREE_W) ? TW : markf_pkg::MIN_FREE_W) + 2;
	localparam logic [AW-1:0] COL_STEP = AW'(MAX_COLS);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_LWR  = 8'b0000_0010,
		S_INIT = 8'b0000_0100,
		S_RD   = 8'b0000_1000,
		S_DEC  = 8'b0001_0000,
		S_AREA = 8'b0010_0000,
		S_PAIR = 8'b0100_0000,
		S_PUT  = 8'b1000_0000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [markf_pkg::DIM_W-1:0]      row_count_q;
	logic [markf_pkg::DIM_W-1:0]      col_count_q;
	logic [markf_pkg::MIN_FREE_W-1:0] min_free_q;
	logic                             cfg_wr;
	logic [1:0]                       cfg_idx;
	logic                             dim_wr;

	// Load counters
	logic [RCW-1:0] row_q;
	logic [CCW-1:0] col_q;
	logic [CCW-1:0] rsum_q;
	logic [AW-1:0]  row_base_q;
	logic           above_en_q;

	// Search pointers
	logic [CCW-1:0] lc_q;
	logic [CCW-1:0] rc_q;
	logic [RCW-1:0] tr_q;
	logic [RCW-1:0] br_q;
	logic [AW-1:0]  tbase_q;
	logic [AW-1:0]  bbase_q;
	logic [2:0]     ph_q;
	logic [AREA_W-1:0] area_q;
	logic [AREA_W-1:0] best_q;

	// Output register
	logic                             res_valid_q;
	logic [markf_pkg::AREA_OUT_W-1:0] min_area_q;

	// Effective dimensions and threshold
	logic [RCW-1:0] rows_eff;
	logic [CCW-1:0] cols_eff;
	logic [markf_pkg::MIN_FREE_W-1:0] need;

	// Memory and shared unit connections
	logic           we;
	logic [AW-1:0]  waddr;
	logic [TW-1:0]  wdata;
	logic [AW-1:0]  raddr;
	logic [TW-1:0]  rdata;
	markf_pkg::acc_ctl_t acc_ctl;
	logic           enough;
	logic [1:0]     crn;

	// Area multiplier
	logic [CCW-1:0]    mul_w;
	logic [RCW-1:0]    mul_h;
	logic [AREA_W-1:0] prod;

	logic cell_acc;
	logic res_take;
	logic put_ok;

	// Clamp dimensions and threshold
	always_comb begin
		if (row_count_q == '0) begin
			rows_eff = RCW'(1);
		end else if (int'(row_count_q) > MAX_ROWS) begin
			rows_eff = RCW'(MAX_ROWS);
		end else begin
			rows_eff = RCW'(row_count_q);
		end
		if (col_count_q == '0) begin
			cols_eff = CCW'(1);
		end else if (int'(col_count_q) > MAX_COLS) begin
			cols_eff = CCW'(MAX_COLS);
		end else begin
			cols_eff = CCW'(col_count_q);
		end
	end

	assign need = (min_free_q == '0) ? markf_pkg::MIN_FREE_W'(1) : min_free_q;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[3:2];
	assign dim_wr  = cfg_wr && (cfg_idx == markf_pkg::REG_ROW_COUNT ||
		cfg_idx == markf_pkg::REG_COL_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= markf_pkg::DIM_W'(1);
			col_count_q <= markf_pkg::DIM_W'(1);
			min_free_q  <= markf_pkg::MIN_FREE_W'(1);
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				markf_pkg::REG_ROW_COUNT: row_count_q <= pwdata[markf_pkg::DIM_W-1:0];
				markf_pkg::REG_COL_COUNT: col_count_q <= pwdata[markf_pkg::DIM_W-1:0];
				markf_pkg::REG_MIN_FREE:  min_free_q  <= pwdata[markf_pkg::MIN_FREE_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		unique case (cfg_idx)
			markf_pkg::REG_ROW_COUNT: prdata = markf_pkg::CFG_DATA_W'(row_count_q);
			markf_pkg::REG_COL_COUNT: prdata = markf_pkg::CFG_DATA_W'(col_count_q);
			markf_pkg::REG_MIN_FREE:  prdata = markf_pkg::CFG_DATA_W'(min_free_q);
			default:                  prdata = '0;
		endcase
	end

	// Handshakes
	assign cell_stall = (state_q != S_IDLE);
	assign cell_acc   = cell_valid && !cell_stall;
	assign res_take   = res_valid_q && !res_stall;
	assign put_ok     = !res_valid_q || !res_stall;
	assign res_valid  = res_valid_q;
	assign min_area   = min_area_q;

	// Corner being accumulated this cycle (issued in the previous cycle)
	assign crn = 2'(ph_q - 3'd1);

	// Table read address: row above while loading, corners while searching
	always_comb begin
		raddr = '0;
		if (state_q == S_IDLE) begin
			if (row_q != '0) begin
				raddr = row_base_q - COL_STEP + AW'(col_q);
			end
		end else if (state_q == S_RD) begin
			case (ph_q[1:0])
				markf_pkg::CRN_LOW_RIGHT: raddr = bbase_q + AW'(rc_q);
				markf_pkg::CRN_LOW_LEFT:
					if (lc_q != '0) raddr = bbase_q + AW'(lc_q) - AW'(1);
				markf_pkg::CRN_TOP_RIGHT:
					if (tr_q != '0) raddr = tbase_q + AW'(rc_q);
				default:
					if (tr_q != '0 && lc_q != '0) raddr = tbase_q + AW'(lc_q) - AW'(1);
			endcase
		end
	end

	// Accumulator control: add the corner read in the previous cycle
	always_comb begin
		acc_ctl.add    = (state_q == S_RD) && (ph_q != 3'd0);
		acc_ctl.first  = (ph_q == 3'd1);
		acc_ctl.negate = (crn == markf_pkg::CRN_LOW_LEFT) || (crn == markf_pkg::CRN_TOP_RIGHT);
		case (crn)
			markf_pkg::CRN_LOW_RIGHT: acc_ctl.take = 1'b1;
			markf_pkg::CRN_LOW_LEFT:  acc_ctl.take = (lc_q != '0);
			markf_pkg::CRN_TOP_RIGHT: acc_ctl.take = (tr_q != '0);
			default:                  acc_ctl.take = (tr_q != '0) && (lc_q != '0);
		endcase
	end

	// Table write in the write state of a cell, after the row-above read
	assign we    = (state_q == S_LWR);
	assign waddr = row_base_q + AW'(col_q);
	assign wdata = TW'(rsum_q) + (above_en_q ? rdata : '0);

	// Area multiplier: grid size at search start, rectangle size otherwise
	always_comb begin
		if (state_q == S_INIT) begin
			mul_w = cols_eff;
			mul_h = rows_eff;
		end else begin
			mul_w = CCW'(rc_q - lc_q + CCW'(1));
			mul_h = RCW'(br_q - tr_q + RCW'(1));
		end
	end

	assign prod = {{RCW{1'b0}}, mul_w} * {{CCW{1'b0}}, mul_h};

	always_ff @(posedge clk) begin
		area_q <= prod;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			row_q      <= '0;
			col_q      <= '0;
			rsum_q     <= '0;
			row_base_q <= '0;
			above_en_q <= 1'b0;
			lc_q       <= '0;
			rc_q       <= '0;
			tr_q       <= '0;
			br_q       <= '0;
			tbase_q    <= '0;
			bbase_q    <= '0;
			ph_q       <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (dim_wr) begin
						// restart the grid
						row_q      <= '0;
						col_q      <= '0;
						rsum_q     <= '0;
						row_base_q <= '0;
					end else if (cell_acc) begin
						rsum_q     <= ((col_q == '0) ? '0 : rsum_q) + CCW'(cell_free);
						above_en_q <= (row_q != '0);
						state_q    <= S_LWR;
					end
				end
				S_LWR: begin
					// advance the cell position
					if (col_q + CCW'(1) == cols_eff) begin
						col_q <= '0;
						if (row_q + RCW'(1) == rows_eff) begin
							row_q      <= '0;
							row_base_q <= '0;
							state_q    <= S_INIT;
						end else begin
							row_q      <= row_q + RCW'(1);
							row_base_q <= row_base_q + COL_STEP;
							state_q    <= S_IDLE;
						end
					end else begin
						col_q   <= col_q + CCW'(1);
						state_q <= S_IDLE;
					end
				end
				S_INIT: begin
					lc_q    <= '0;
					rc_q    <= '0;
					tr_q    <= '0;
					br_q    <= '0;
					tbase_q <= '0;
					bbase_q <= '0;
					ph_q    <= '0;
					state_q <= S_RD;
				end
				S_RD: begin
					if (ph_q == 3'd4) begin
						ph_q    <= '0;
						state_q <= S_DEC;
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				S_DEC: begin
					if (enough) begin
						state_q <= S_AREA;
					end else if (br_q + RCW'(1) < rows_eff) begin
						// grow the rectangle downwards
						br_q    <= br_q + RCW'(1);
						bbase_q <= bbase_q + COL_STEP;
						state_q <= S_RD;
					end else begin
						state_q <= S_PAIR;
					end
				end
				S_AREA: begin
					// shrink from the top
					tr_q    <= tr_q + RCW'(1);
					tbase_q <= (tr_q == '0) ? '0 : tbase_q + COL_STEP;
					state_q <= (tr_q + RCW'(1) >= rows_eff) ? S_PAIR : S_RD;
				end
				S_PAIR: begin
					tr_q    <= '0;
					br_q    <= '0;
					tbase_q <= '0;
					bbase_q <= '0;
					if (rc_q + CCW'(1) < cols_eff) begin
						rc_q    <= rc_q + CCW'(1);
						state_q <= S_RD;
					end else if (lc_q + CCW'(1) < cols_eff) begin
						lc_q    <= lc_q + CCW'(1);
						rc_q    <= lc_q + CCW'(1);
						state_q <= S_RD;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					if (put_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Track the best area
	always_ff @(posedge clk) begin
		if (state_q == S_INIT) begin
			best_q <= prod;
		end else if (state_q == S_AREA && area_q < best_q) begin
			best_q <= area_q;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_PUT && put_ok) begin
			res_valid_q <= 1'b1;
		end else if (res_take) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_PUT && put_ok) begin
			min_area_q <= markf_pkg::AREA_OUT_W'(best_q);
		end
	end

	markf_table_ram #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (TW)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	markf_acc_unit #(
		.DW    (TW),
		.ACC_W (ACC_W)
	) u_acc (
		.clk    (clk),
		.ctl    (acc_ctl),
		.data   (rdata),
		.need   (need),
		.enough (enough)
	);

endmodule
